// ===== rtl/aefp_pkg.sv =====
// Shared types and constants for the ASCII encoder frame parser.
// Used by every module under rtl; depends on nothing else.
package aefp_pkg;

    // Field and counter widths
    localparam int BYTE_BITS     = 8;
    localparam int COUNT_BITS    = 32;
    localparam int STREAK_BITS   = 8;
    localparam int TIMEOUT_BITS  = 16;
    localparam int LIMIT_BITS    = 8;
    localparam int TOKEN_BITS    = 3;
    localparam int AXES          = 4;
    localparam int AXIS_IDX_BITS = 2;
    localparam int OUT_POS_BITS  = 32;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam int POSITION_BITS_DEFAULT = 32;

    // Register reset values
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET    = 16'd1000;
    localparam logic [LIMIT_BITS-1:0]   LINE_LIMIT_RESET = 8'd64;

    // Token counting: token 0 is the label, tokens 1..4 carry the axes
    localparam logic [TOKEN_BITS-1:0] TOKEN_MAX         = 3'd5;
    localparam logic [TOKEN_BITS-1:0] FIRST_VALUE_TOKEN = 3'd2;

    // Characters of interest
    localparam logic [BYTE_BITS-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_BITS-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_BITS-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_BITS-1:0] CHAR_NINE  = 8'h39;

    // Input item kind
    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } aefp_req_t;

    // Configuration register index
    typedef enum logic {
        REG_TIMEOUT    = 1'b0,
        REG_LINE_LIMIT = 1'b1
    } aefp_reg_t;

    // Line control to number parser
    typedef struct packed {
        logic                 start;   // a new line opens with this byte
        logic                 parse;   // byte fits the line and is parsed
        logic [BYTE_BITS-1:0] data;
    } aefp_parse_ctrl_t;

    // Line events for the statistics
    typedef struct packed {
        logic tick;
        logic done;
        logic good;
        logic bad;
    } aefp_event_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  frames;
        logic [COUNT_BITS-1:0]  goods;
        logic [COUNT_BITS-1:0]  bads;
        logic [COUNT_BITS-1:0]  stales;
        logic [STREAK_BITS-1:0] streak;
    } aefp_counts_t;

endpackage

// ===== rtl/aefp_cfg_regs.sv =====
// APB register file for the frame parser: timeout and line limit.
// Depends on aefp_pkg.
module aefp_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aefp_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [aefp_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [aefp_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output logic [aefp_pkg::TIMEOUT_BITS-1:0]   timeout_ms,
    output logic [aefp_pkg::LIMIT_BITS-1:0]     line_limit
);
    import aefp_pkg::*;

    logic [TIMEOUT_BITS-1:0] timeout_reg;
    logic [LIMIT_BITS-1:0]   limit_reg;
    aefp_reg_t               reg_sel;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_sel = aefp_reg_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            limit_reg   <= LINE_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_TIMEOUT:    timeout_reg <= pwdata[TIMEOUT_BITS-1:0];
                REG_LINE_LIMIT: limit_reg   <= pwdata[LIMIT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_sel)
            REG_TIMEOUT:    prdata = APB_DATA_BITS'(timeout_reg);
            REG_LINE_LIMIT: prdata = APB_DATA_BITS'(limit_reg);
            default:        prdata = '0;
        endcase
    end

    assign timeout_ms = timeout_reg;
    assign line_limit = limit_reg;

endmodule

// ===== rtl/aefp_num_parser.sv =====
// Token splitter and signed decimal reader for one line; holds the
// four pending axis values. Depends on aefp_pkg.
module aefp_num_parser #(
    parameter int POSITION_BITS = aefp_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  aefp_pkg::aefp_parse_ctrl_t    ctrl,
    output logic                          tok_full,
    output logic signed [POSITION_BITS-1:0] pending [aefp_pkg::AXES]
);
    import aefp_pkg::*;

    localparam int PW = POSITION_BITS + 4;
    localparam logic [POSITION_BITS-1:0] MAG_CAP = {1'b1, {(POSITION_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        PH_BLANK  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    logic                     nul_reg,   nul_next,   nul_cur;
    logic                     tok_reg,   tok_next,   tok_cur;
    logic [TOKEN_BITS-1:0]    tc_reg,    tc_next,    tc_cur;
    phase_t                   ph_reg,    ph_next,    ph_cur, ph_eff;
    logic                     neg_reg,   neg_next,   neg_cur;
    logic [POSITION_BITS-1:0] mag_reg,   mag_next,   mag_cur;
    logic signed [POSITION_BITS-1:0] pend_reg [AXES];
    logic signed [POSITION_BITS-1:0] pend_next [AXES];

    logic                     is_digit, is_blank, is_sign;
    logic                     clr_slot, dig_slot;
    logic [TOKEN_BITS-1:0]    slot_full;
    logic [AXIS_IDX_BITS-1:0] slot;
    logic [PW-1:0]            prod;
    logic [POSITION_BITS-1:0] mag_dig;
    logic [POSITION_BITS-1:0] value;
    logic [BYTE_BITS-1:0]     c;

    assign c        = ctrl.data;
    assign is_digit = c inside {[CHAR_ZERO:CHAR_NINE]};
    assign is_blank = (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
    assign is_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);

    // Opening a line starts from a clean parse state
    always_comb
    begin
        nul_cur = ctrl.start ? 1'b0 : nul_reg;
        tok_cur = ctrl.start ? 1'b0 : tok_reg;
        tc_cur  = ctrl.start ? '0   : tc_reg;
        ph_cur  = ctrl.start ? PH_BLANK : ph_reg;
        neg_cur = ctrl.start ? 1'b0 : neg_reg;
        mag_cur = ctrl.start ? '0   : mag_reg;
    end

    // Advance the token and number state by one byte
    always_comb
    begin
        nul_next = nul_cur;
        tok_next = tok_cur;
        tc_next  = tc_cur;
        ph_eff   = ph_cur;
        neg_next = neg_cur;
        mag_next = mag_cur;
        clr_slot = 1'b0;
        if (ctrl.parse && !nul_cur)
        begin
            if (c == CHAR_NUL)
            begin
                nul_next = 1'b1;
            end
            else if (c == CHAR_COMMA)
            begin
                tok_next = 1'b0;
            end
            else if (!tok_cur)
            begin
                tok_next = 1'b1;
                neg_next = 1'b0;
                mag_next = '0;
                if (tc_cur >= TOKEN_MAX)
                begin
                    ph_eff = PH_DONE;
                end
                else
                begin
                    tc_next = tc_cur + 1'b1;
                    if (tc_next >= FIRST_VALUE_TOKEN)
                    begin
                        ph_eff   = PH_BLANK;
                        clr_slot = 1'b1;
                    end
                    else
                    begin
                        ph_eff = PH_DONE;
                    end
                end
            end
        end
    end

    // Classify the byte in the current number phase
    always_comb
    begin
        ph_next  = ph_eff;
        dig_slot = 1'b0;
        if (ctrl.parse && !nul_cur && c != CHAR_NUL && c != CHAR_COMMA)
        begin
            case (ph_eff)
                PH_BLANK:
                begin
                    if (is_blank)
                    begin
                        ph_next = PH_BLANK;
                    end
                    else if (is_sign)
                    begin
                        ph_next = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        ph_next  = PH_DIGITS;
                        dig_slot = 1'b1;
                    end
                    else
                    begin
                        ph_next = PH_DONE;
                    end
                end
                PH_SIGN, PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        ph_next  = PH_DIGITS;
                        dig_slot = 1'b1;
                    end
                    else
                    begin
                        ph_next = PH_DONE;
                    end
                end
                default: ph_next = PH_DONE;
            endcase
        end
    end

    // Sign from the sign byte, only in the blank phase
    logic neg_out;
    assign neg_out = (ctrl.parse && !nul_cur && ph_eff == PH_BLANK && is_sign)
                     ? (c == CHAR_MINUS) : neg_next;

    // Multiply by ten and add the digit, saturating at the magnitude cap
    always_comb
    begin
        prod    = PW'({mag_next, 3'b000}) + PW'({mag_next, 1'b0})
                + PW'(c - CHAR_ZERO);
        mag_dig = (prod > PW'(MAG_CAP)) ? MAG_CAP : prod[POSITION_BITS-1:0];
        if (neg_out)
            value = {POSITION_BITS{1'b0}} - mag_dig;
        else
            value = mag_dig[POSITION_BITS-1] ? (MAG_CAP - 1'b1) : mag_dig;
    end

    assign slot_full = tc_next - FIRST_VALUE_TOKEN;
    assign slot      = slot_full[AXIS_IDX_BITS-1:0];

    // Pending values: cleared at line open and token start, loaded per digit
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            pend_next[i] = ctrl.start ? '0 : pend_reg[i];
            if (clr_slot && slot == AXIS_IDX_BITS'(i))
                pend_next[i] = '0;
            if (dig_slot && slot == AXIS_IDX_BITS'(i))
                pend_next[i] = value;
        end
    end

    // Hold state unless a byte opens or extends a line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nul_reg <= 1'b0;
            tok_reg <= 1'b0;
            tc_reg  <= '0;
            ph_reg  <= PH_BLANK;
            neg_reg <= 1'b0;
            mag_reg <= '0;
            for (int i = 0; i < AXES; i++)
                pend_reg[i] <= '0;
        end
        else if (ctrl.start || ctrl.parse)
        begin
            nul_reg <= nul_next;
            tok_reg <= tok_next;
            tc_reg  <= tc_next;
            ph_reg  <= ph_next;
            neg_reg <= neg_out;
            mag_reg <= dig_slot ? mag_dig : mag_next;
            for (int i = 0; i < AXES; i++)
                pend_reg[i] <= pend_next[i];
        end
    end

    assign tok_full = (tc_reg >= TOKEN_MAX);
    assign pending  = pend_reg;

endmodule

// ===== rtl/aefp_line_ctrl.sv =====
// Line framing: open, length check, CR/LF termination and event decode.
// Depends on aefp_pkg.
module aefp_line_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  aefp_pkg::aefp_req_t               req_type,
    input  logic [aefp_pkg::BYTE_BITS-1:0]    rx_byte,
    input  logic [aefp_pkg::LIMIT_BITS-1:0]   line_limit,
    input  logic                              tok_full,
    output aefp_pkg::aefp_parse_ctrl_t        ctrl,
    output aefp_pkg::aefp_event_t             ev
);
    import aefp_pkg::*;

    logic                  in_line_reg, in_line_next;
    logic [LIMIT_BITS-1:0] count_reg,   count_next, count_cur;
    logic [LIMIT_BITS-1:0] room;
    logic                  is_term, is_byte, fits;

    assign is_byte   = step && (req_type == REQ_BYTE);
    assign is_term   = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    assign room      = (line_limit >= LIMIT_BITS'(1)) ? line_limit - 1'b1 : '0;
    assign count_cur = in_line_reg ? count_reg : '0;
    assign fits      = count_cur < room;

    // Decode the beat into parser control and line events
    always_comb
    begin
        in_line_next = in_line_reg;
        count_next   = count_reg;
        ctrl.start   = 1'b0;
        ctrl.parse   = 1'b0;
        ctrl.data    = rx_byte;
        ev.tick      = step && (req_type == REQ_TICK);
        ev.done      = 1'b0;
        ev.good      = 1'b0;
        ev.bad       = 1'b0;
        if (is_byte && is_term)
        begin
            if (in_line_reg)
            begin
                in_line_next = 1'b0;
                count_next   = '0;
                ev.done      = 1'b1;
                ev.good      = tok_full;
                ev.bad       = !tok_full;
            end
        end
        else if (is_byte)
        begin
            ctrl.start = !in_line_reg;
            if (fits)
            begin
                in_line_next = 1'b1;
                count_next   = count_cur + 1'b1;
                ctrl.parse   = 1'b1;
            end
            else
            begin
                // Overflow: drop the byte and abandon the line
                in_line_next = 1'b0;
                count_next   = '0;
                ev.bad       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_line_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            in_line_reg <= in_line_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ===== rtl/aefp_stats.sv =====
// Positions, frame counters and millisecond stale timeout.
// Depends on aefp_pkg; takes pending values from the number parser.
module aefp_stats #(
    parameter int POSITION_BITS = aefp_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  aefp_pkg::aefp_event_t             ev,
    input  logic [aefp_pkg::TIMEOUT_BITS-1:0] timeout_ms,
    input  logic signed [POSITION_BITS-1:0]   pending [aefp_pkg::AXES],
    output logic signed [POSITION_BITS-1:0]   pos_next [aefp_pkg::AXES],
    output aefp_pkg::aefp_counts_t            counts_next
);
    import aefp_pkg::*;

    logic signed [POSITION_BITS-1:0] pos_reg [AXES];
    aefp_counts_t                    counts_reg;
    logic [TIMEOUT_BITS-1:0]         ms_reg, ms_next;
    logic [TIMEOUT_BITS:0]           ms_inc;

    assign ms_inc = {1'b0, ms_reg} + 1'b1;

    // Update counters for this beat
    always_comb
    begin
        counts_next = counts_reg;
        ms_next     = ms_reg;
        for (int i = 0; i < AXES; i++)
            pos_next[i] = ev.good ? pending[i] : pos_reg[i];
        if (ev.tick)
        begin
            if (ms_inc > {1'b0, timeout_ms})
            begin
                counts_next.stales = counts_reg.stales + 1'b1;
                counts_next.streak = counts_reg.streak + 1'b1;
                ms_next            = '0;
            end
            else
            begin
                ms_next = ms_inc[TIMEOUT_BITS-1:0];
            end
        end
        if (ev.done)
            counts_next.frames = counts_reg.frames + 1'b1;
        if (ev.good)
        begin
            counts_next.goods  = counts_reg.goods + 1'b1;
            counts_next.streak = '0;
            ms_next            = '0;
        end
        if (ev.bad)
            counts_next.bads = counts_reg.bads + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= '0;
            ms_reg     <= '0;
            for (int i = 0; i < AXES; i++)
                pos_reg[i] <= '0;
        end
        else
        begin
            counts_reg <= counts_next;
            ms_reg     <= ms_next;
            for (int i = 0; i < AXES; i++)
                pos_reg[i] <= pos_next[i];
        end
    end

    // A good line is always a finished line
    a_good_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        ev.good |-> ev.done && !ev.bad)
        else $error("good line without line end");

    // Every finished line bumps the frame count by one
    a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
        ev.done |=> counts_reg.frames == $past(counts_reg.frames) + 1'b1)
        else $error("frame count did not advance");

    // A good line restarts the stale timer and streak
    a_good_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ev.good |=> ms_reg == '0 && counts_reg.streak == '0)
        else $error("good line did not clear stale state");

    // Counters rest when no event arrives
    a_quiet_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(ev.tick || ev.done || ev.bad) |=> $stable(counts_reg))
        else $error("counters moved without an event");

endmodule

// ===== rtl/ascii_encoder_frame_parser.sv =====
// Top level of the ASCII encoder frame parser: stream ports, APB port,
// input and result registers. Depends on aefp_pkg and the aefp_* modules.
//
// Accepts one beat per clock unless the result side stalls: a received
// byte or a millisecond tick. Each beat yields exactly one result beat,
// carrying the line end and line good flags with the current positions and
// counters. Beats pass through an input register, the line, token and
// number logic that updates the parser state, and a result register; the
// parser state loop closes in that logic, so throughput is one beat per
// cycle. No clearing pass follows reset. The user must write configuration
// over APB only while the stream is idle; the block does not enforce it.
module ascii_encoder_frame_parser #(
    parameter int POSITION_BITS = aefp_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] rx_byte
    input  logic                                s_tuser,  // [0] req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] position_a, [63:32] position_b, [95:64] position_c,
    // [127:96] position_d, [159:128] frame_total, [191:160] good_total,
    // [223:192] bad_total, [255:224] stale_total, [263:256] stale_run
    output logic [263:0]                        m_tdata,
    output logic [1:0]                          m_tuser,  // [0] line_done, [1] line_good
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aefp_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [aefp_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [aefp_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import aefp_pkg::*;

    logic                    in_valid_reg;
    aefp_req_t               in_type_reg;
    logic [BYTE_BITS-1:0]    in_byte_reg;
    logic                    out_valid_reg;
    logic [263:0]            out_data_reg;
    logic [1:0]              out_user_reg;
    logic                    out_ready, step;

    logic [TIMEOUT_BITS-1:0] timeout_ms;
    logic [LIMIT_BITS-1:0]   line_limit;
    aefp_parse_ctrl_t        ctrl;
    aefp_event_t             ev;
    logic                    tok_full;
    logic signed [POSITION_BITS-1:0] pending  [AXES];
    logic signed [POSITION_BITS-1:0] pos_next [AXES];
    aefp_counts_t            counts_next;
    logic [263:0]            result;

    assign out_ready = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_type_reg  <= REQ_BYTE;
            in_byte_reg  <= '0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
            if (s_tvalid)
            begin
                in_type_reg <= aefp_req_t'(s_tuser);
                in_byte_reg <= s_tdata;
            end
        end
    end

    aefp_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .timeout_ms (timeout_ms),
        .line_limit (line_limit)
    );

    aefp_line_ctrl u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .req_type   (in_type_reg),
        .rx_byte    (in_byte_reg),
        .line_limit (line_limit),
        .tok_full   (tok_full),
        .ctrl       (ctrl),
        .ev         (ev)
    );

    aefp_num_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .tok_full (tok_full),
        .pending  (pending)
    );

    aefp_stats #(
        .POSITION_BITS (POSITION_BITS)
    ) u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev          (ev),
        .timeout_ms  (timeout_ms),
        .pending     (pending),
        .pos_next    (pos_next),
        .counts_next (counts_next)
    );

    // Pack the result beat; positions carry their low 32 bits
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
            result[i*OUT_POS_BITS +: OUT_POS_BITS] = OUT_POS_BITS'(pos_next[i]);
        result[159:128] = counts_next.frames;
        result[191:160] = counts_next.goods;
        result[223:192] = counts_next.bads;
        result[255:224] = counts_next.stales;
        result[263:256] = counts_next.streak;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= in_valid_reg;
            if (step)
            begin
                out_data_reg <= result;
                out_user_reg <= {ev.good, ev.done};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
